// File: src/cnms_pkg.sv
// -----------------------------------------------------------------------------
// cnms_pkg
// Shared types, constants and calendar helpers for the cron next-match search.
// -----------------------------------------------------------------------------
package cnms_pkg;

   localparam int SEARCH_MONTHS = 336;
   localparam int MCNT_W        = $clog2(SEARCH_MONTHS);

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int CENT_W   = 8;
   localparam int YREM_W   = 7;
   localparam int WSUM_W   = 15;

   localparam int FIELDS_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W;
   localparam int DATA_W   = ((FIELDS_W + 7) / 8) * 8;

   localparam int VEC_W    = 60;
   localparam int IDX_W    = 6;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_IDX_LSB = 3;
   localparam int CSR_IDX_W   = CSR_ADDR_W - CSR_IDX_LSB;

   localparam logic [CSR_IDX_W-1:0] RegMinute  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] RegHour    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] RegDom     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] RegMonth   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] RegWeekday = 3'd4;

   localparam logic [YEAR_W-1:0] MaxYear = 14'd9999;
   localparam logic [10:0]       Recip25 = 11'd1311;   // 2^15 / 25, rounded up

   typedef struct packed {
      logic [59:0] minute;
      logic [23:0] hour;
      logic [31:0] dom;
      logic [12:0] month;
      logic [7:0]  weekday;
   } mask_type;

   function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] mo,
                                                      input logic leap);
      logic [DAY_W-1:0] dim;
      case (mo)
         4'd2:    dim = leap ? 5'd29 : 5'd28;
         4'd4:    dim = 5'd30;
         4'd6:    dim = 5'd30;
         4'd9:    dim = 5'd30;
         4'd11:   dim = 5'd30;
         default: dim = 5'd31;
      endcase
      return dim;
   endfunction

   function automatic logic [2:0] dow_offset(input logic [MONTH_W-1:0] mo);
      logic [2:0] off;
      case (mo)
         4'd1:    off = 3'd0;
         4'd2:    off = 3'd3;
         4'd3:    off = 3'd2;
         4'd4:    off = 3'd5;
         4'd5:    off = 3'd0;
         4'd6:    off = 3'd3;
         4'd7:    off = 3'd5;
         4'd8:    off = 3'd1;
         4'd9:    off = 3'd4;
         4'd10:   off = 3'd6;
         4'd11:   off = 3'd2;
         4'd12:   off = 3'd4;
         default: off = 3'd0;
      endcase
      return off;
   endfunction

   // x mod 7 by folding octal digits (8 = 1 mod 7)
   function automatic logic [2:0] mod7(input logic [WSUM_W-1:0] x);
      logic [5:0] s1;
      logic [3:0] s2;
      logic [3:0] s3;
      s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
      s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
      s3 = 4'(s2[3]) + 4'(s2[2:0]);
      return (s3 == 4'd7) ? 3'd0 : s3[2:0];
   endfunction

endpackage

// File: src/cron_next_match_search.sv
// -----------------------------------------------------------------------------
// cron_next_match_search
// Finds the first minute at or after a start time that matches five cron masks.
// -----------------------------------------------------------------------------
//  channel  | direction | contents
//  req_*    | in        | one start time word per search
//  rsp_*    | out       | one result word per search, found flag on tuser
//  csr_*    | in/out    | APB mask registers at byte address 8*i
//
// A search runs setup (CENT, REM, CHECK, WDAY, H1, M1, H1B, M0, H0), then walks
// one day per cycle in an allowed month and one skipped month per cycle, over at
// most SEARCH_MONTHS months. An invalid start goes from CHECK to the result.
// Reset is synchronous and clears the masks and the sequencer; no clearing pass.
// req_tready stays low from acceptance until the result word is taken.
// -----------------------------------------------------------------------------
module cron_next_match_search (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // start_year, start_month, start_day, start_hour, start_minute
   input  logic [cnms_pkg::DATA_W-1:0]       req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // match_year, match_month, match_day, match_hour, match_minute
   output logic [cnms_pkg::DATA_W-1:0]       rsp_tdata,
   // found
   output logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cnms_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cnms_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cnms_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import cnms_pkg::*;

   mask_type masks;

   cnms_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .masks       (masks)
   );

   cnms_search u_search (
      .clock      (clock),
      .reset      (reset),
      .masks      (masks),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: src/cnms_csr.sv
// -----------------------------------------------------------------------------
// cnms_csr
// Mask register file behind the APB-style configuration port.
// -----------------------------------------------------------------------------
module cnms_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cnms_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cnms_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cnms_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output cnms_pkg::mask_type                masks
);
   import cnms_pkg::*;

   mask_type               masks_ff, masks_in;
   logic [CSR_IDX_W-1:0]   idx;
   logic                   wr_en;

   assign idx        = csr_paddr[CSR_ADDR_W-1:CSR_IDX_LSB];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign masks      = masks_ff;

   always_comb begin
      masks_in = masks_ff;
      if (wr_en) begin
         case (idx)
            RegMinute:  masks_in.minute  = csr_pwdata[59:0];
            RegHour:    masks_in.hour    = csr_pwdata[23:0];
            RegDom:     masks_in.dom     = csr_pwdata[31:0];
            RegMonth:   masks_in.month   = csr_pwdata[12:0];
            RegWeekday: masks_in.weekday = csr_pwdata[7:0];
            default:    masks_in = masks_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         RegMinute:  csr_prdata = CSR_DATA_W'(masks_ff.minute);
         RegHour:    csr_prdata = CSR_DATA_W'(masks_ff.hour);
         RegDom:     csr_prdata = CSR_DATA_W'(masks_ff.dom);
         RegMonth:   csr_prdata = CSR_DATA_W'(masks_ff.month);
         RegWeekday: csr_prdata = CSR_DATA_W'(masks_ff.weekday);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         masks_ff <= '0;
      end else begin
         masks_ff <= masks_in;
      end
   end

endmodule

// File: src/cnms_first_bit.sv
// -----------------------------------------------------------------------------
// cnms_first_bit
// Shared search unit: lowest set bit of a mask at or above a start index.
// -----------------------------------------------------------------------------
module cnms_first_bit (
   input  logic [cnms_pkg::VEC_W-1:0] vec,
   input  logic [cnms_pkg::IDX_W-1:0] from,
   output logic                       found,
   output logic [cnms_pkg::IDX_W-1:0] idx
);
   import cnms_pkg::*;

   always_comb begin
      found = 1'b0;
      idx   = '0;
      for (int i = VEC_W - 1; i >= 0; i--) begin
         if (vec[i] && (IDX_W'(i) >= from)) begin
            found = 1'b1;
            idx   = IDX_W'(i);
         end
      end
   end

endmodule

// File: src/cnms_search.sv
// -----------------------------------------------------------------------------
// cnms_search
// Sequencer: start check, weekday setup, time-of-day lookups through the shared
// search unit, then a day/month calendar walk with a registered result.
// -----------------------------------------------------------------------------
module cnms_search (
   input  logic                          clock,
   input  logic                          reset,
   input  cnms_pkg::mask_type            masks,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cnms_pkg::DATA_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cnms_pkg::DATA_W-1:0]   rsp_tdata,
   output logic                          rsp_tuser
);
   import cnms_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CENT, ST_REM, ST_CHECK, ST_WDAY,
      ST_H1, ST_M1, ST_H1B, ST_M0, ST_H0, ST_SCAN, ST_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic [YEAR_W-1:0]       y_ff, y_in;
   logic [MONTH_W-1:0]      mo_ff, mo_in;
   logic [DAY_W-1:0]        d_ff, d_in;
   logic [HOUR_W-1:0]       h_ff, h_in;
   logic [MINUTE_W-1:0]     mi_ff, mi_in;
   logic [CENT_W-1:0]       cent_ff, cent_in;
   logic [YREM_W-1:0]       yrem_ff, yrem_in;
   logic [WSUM_W-1:0]       wsum_ff, wsum_in;
   logic [2:0]              w_ff, w_in;
   logic [MCNT_W-1:0]       n_ff, n_in;
   logic                    first_ff, first_in;
   logic                    h1_ok_ff, h1_ok_in, m1_ok_ff, m1_ok_in;
   logic                    h1b_ok_ff, h1b_ok_in, m0_ok_ff, m0_ok_in, h0_ok_ff, h0_ok_in;
   logic [IDX_W-1:0]        h1_ff, h1_in, m1_ff, m1_in, h1b_ff, h1b_in;
   logic [IDX_W-1:0]        m0_ff, m0_in, h0_ff, h0_in;
   logic                    found_ff, found_in;
   logic [DATA_W-1:0]       data_ff, data_in;

   logic [VEC_W-1:0]        fb_vec;
   logic [IDX_W-1:0]        fb_from;
   logic                    fb_found;
   logic [IDX_W-1:0]        fb_idx;

   logic [22:0]             prod;
   logic                    leap;
   logic [DAY_W-1:0]        dim;
   logic                    mlt3;
   logic [YEAR_W-1:0]       yy;
   logic [CENT_W-1:0]       cy;
   logic                    start_ok;
   logic [2:0]              wrem;
   logic [5:0]              skip;
   logic [2:0]              wadv;
   logic                    t_ok;
   logic [IDX_W-1:0]        t_h, t_m;
   logic                    wday_ok;
   logic                    hit;

   cnms_first_bit u_first_bit (
      .vec   (fb_vec),
      .from  (fb_from),
      .found (fb_found),
      .idx   (fb_idx)
   );

   assign prod  = 23'(y_ff[YEAR_W-1:2]) * 23'(Recip25);
   assign leap  = (y_ff[1:0] == 2'd0) && ((yrem_ff != '0) || (cent_ff[1:0] == 2'd0));
   assign dim   = days_in_month(mo_ff, leap);
   assign mlt3  = (mo_ff < 4'd3);
   assign yy    = mlt3 ? y_ff - 14'd1 : y_ff;
   assign cy    = (mlt3 && (yrem_ff == '0)) ? cent_ff - 8'd1 : cent_ff;
   assign wrem  = mod7(wsum_ff);
   assign skip  = 6'(w_ff - 3'd1) + 6'(dim) - 6'(d_ff) + 6'd1;
   assign wadv  = mod7(WSUM_W'(skip)) + 3'd1;

   assign start_ok = (y_ff >= 14'd1) && (y_ff <= MaxYear)
                  && (mo_ff >= 4'd1) && (mo_ff <= 4'd12)
                  && (h_ff <= 5'd23) && (mi_ff <= 6'd59)
                  && (d_ff >= 5'd1) && (d_ff <= dim);

   // first day uses the start time, later days start at midnight
   always_comb begin
      if (first_ff) begin
         t_ok = h1_ok_ff && (m1_ok_ff || ((h1_ff < 6'd23) && h1b_ok_ff && m0_ok_ff));
         t_h  = m1_ok_ff ? h1_ff : h1b_ff;
         t_m  = m1_ok_ff ? m1_ff : m0_ff;
      end else begin
         t_ok = h0_ok_ff && m0_ok_ff;
         t_h  = h0_ff;
         t_m  = m0_ff;
      end
   end

   assign wday_ok = masks.weekday[w_ff] || ((w_ff == 3'd7) && masks.weekday[0]);
   assign hit     = masks.month[mo_ff] && masks.dom[d_ff] && wday_ok && t_ok;

   always_comb begin
      case (state_ff)
         ST_H1:   begin fb_vec = VEC_W'(masks.hour); fb_from = IDX_W'(h_ff);   end
         ST_M1:   begin
            fb_vec  = masks.minute;
            fb_from = (h1_ff == IDX_W'(h_ff)) ? mi_ff : '0;
         end
         ST_H1B:  begin fb_vec = VEC_W'(masks.hour); fb_from = h1_ff + 6'd1; end
         ST_H0:   begin fb_vec = VEC_W'(masks.hour); fb_from = '0;            end
         default: begin fb_vec = masks.minute;       fb_from = '0;            end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      y_in      = y_ff;
      mo_in     = mo_ff;
      d_in      = d_ff;
      h_in      = h_ff;
      mi_in     = mi_ff;
      cent_in   = cent_ff;
      yrem_in   = yrem_ff;
      wsum_in   = wsum_ff;
      w_in      = w_ff;
      n_in      = n_ff;
      first_in  = first_ff;
      h1_ok_in  = h1_ok_ff;
      m1_ok_in  = m1_ok_ff;
      h1b_ok_in = h1b_ok_ff;
      m0_ok_in  = m0_ok_ff;
      h0_ok_in  = h0_ok_ff;
      h1_in     = h1_ff;
      m1_in     = m1_ff;
      h1b_in    = h1b_ff;
      m0_in     = m0_ff;
      h0_in     = h0_ff;
      found_in  = found_ff;
      data_in   = data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               y_in     = req_tdata[13:0];
               mo_in    = req_tdata[17:14];
               d_in     = req_tdata[22:18];
               h_in     = req_tdata[27:23];
               mi_in    = req_tdata[33:28];
               state_in = ST_CENT;
            end
         end
         ST_CENT: begin
            cent_in  = prod[22:15];
            state_in = ST_REM;
         end
         ST_REM: begin
            yrem_in  = YREM_W'(y_ff - YEAR_W'(cent_ff * 14'd100));
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            wsum_in = WSUM_W'(yy) + WSUM_W'(yy[YEAR_W-1:2]) - WSUM_W'(cy)
                    + WSUM_W'(cy[CENT_W-1:2]) + WSUM_W'(dow_offset(mo_ff))
                    + WSUM_W'(d_ff);
            if (start_ok) begin
               state_in = ST_WDAY;
            end else begin
               found_in = 1'b0;
               data_in  = '0;
               state_in = ST_OUT;
            end
         end
         ST_WDAY: begin
            w_in     = (wrem == 3'd0) ? 3'd7 : wrem;
            n_in     = '0;
            first_in = 1'b1;
            state_in = ST_H1;
         end
         ST_H1: begin
            h1_ok_in = fb_found;
            h1_in    = fb_idx;
            state_in = ST_M1;
         end
         ST_M1: begin
            m1_ok_in = fb_found;
            m1_in    = fb_idx;
            state_in = ST_H1B;
         end
         ST_H1B: begin
            h1b_ok_in = fb_found;
            h1b_in    = fb_idx;
            state_in  = ST_M0;
         end
         ST_M0: begin
            m0_ok_in = fb_found;
            m0_in    = fb_idx;
            state_in = ST_H0;
         end
         ST_H0: begin
            h0_ok_in = fb_found;
            h0_in    = fb_idx;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (hit) begin
               found_in = 1'b1;
               data_in  = DATA_W'({t_m[MINUTE_W-1:0], t_h[HOUR_W-1:0], d_ff, mo_ff, y_ff});
               state_in = ST_OUT;
            end else if (masks.month[mo_ff] && (d_ff < dim)) begin
               d_in     = d_ff + 5'd1;
               w_in     = (w_ff == 3'd7) ? 3'd1 : w_ff + 3'd1;
               first_in = 1'b0;
            end else if ((mo_ff == 4'd12) && (y_ff >= MaxYear)) begin
               found_in = 1'b0;
               data_in  = '0;
               state_in = ST_OUT;
            end else if (n_ff == MCNT_W'(SEARCH_MONTHS - 1)) begin
               found_in = 1'b0;
               data_in  = '0;
               state_in = ST_OUT;
            end else begin
               n_in     = n_ff + 1'b1;
               d_in     = 5'd1;
               w_in     = wadv;
               first_in = 1'b0;
               if (mo_ff == 4'd12) begin
                  mo_in = 4'd1;
                  y_in  = y_ff + 14'd1;
                  if (yrem_ff == 7'd99) begin
                     yrem_in = '0;
                     cent_in = cent_ff + 8'd1;
                  end else begin
                     yrem_in = yrem_ff + 7'd1;
                  end
               end else begin
                  mo_in = mo_ff + 4'd1;
               end
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      y_ff      <= y_in;
      mo_ff     <= mo_in;
      d_ff      <= d_in;
      h_ff      <= h_in;
      mi_ff     <= mi_in;
      cent_ff   <= cent_in;
      yrem_ff   <= yrem_in;
      wsum_ff   <= wsum_in;
      w_ff      <= w_in;
      n_ff      <= n_in;
      first_ff  <= first_in;
      h1_ok_ff  <= h1_ok_in;
      m1_ok_ff  <= m1_ok_in;
      h1b_ok_ff <= h1b_ok_in;
      m0_ok_ff  <= m0_ok_in;
      h0_ok_ff  <= h0_ok_in;
      h1_ff     <= h1_in;
      m1_ff     <= m1_in;
      h1b_ff    <= h1b_in;
      m0_ff     <= m0_in;
      h0_ff     <= h0_in;
      found_ff  <= found_in;
      data_ff   <= data_in;
   end

endmodule
